FILE: rtl/ptb_pkg.sv
package ptb_pkg;

    localparam int NUM_TIMERS_DEF = 8;

    localparam int IN_BYTES  = 3;
    localparam int OUT_BYTES = 7;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_REQUEST    = 3'd1,
        OP_SET_PERIOD = 3'd2,
        OP_RESTART    = 3'd3,
        OP_RELEASE    = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_ZERO = 2'd2
    } status_t;

    // Operation token handed from cell to cell along the chain
    typedef struct packed {
        logic        valid;
        opcode_t     opcode;
        logic [2:0]  timer_id;
        logic [15:0] period_ms;
        logic        claimed;
        logic [2:0]  granted_id;
        logic [7:0]  expired_mask;
        logic [3:0]  active_count;
    } token_t;

    // Result layout, status in the lowest bits
    typedef struct packed {
        logic [3:0]  active_count;
        logic [31:0] time_ms;
        logic [7:0]  expired_mask;
        logic [2:0]  granted_id;
        status_t     status;
    } result_t;

endpackage

FILE: rtl/ptb_cell.sv
module ptb_cell
    import ptb_pkg::*;
#(
    parameter int CELL_IDX = 0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  token_t tok_in,
    output token_t tok_out
);

    localparam bit         ID_OK    = (CELL_IDX < 8);
    localparam logic [7:0] EXP_BIT  = ID_OK ? 8'(1 << (CELL_IDX % 8)) : 8'd0;
    localparam logic [2:0] GRANT_ID = 3'(CELL_IDX % 8);

    logic [15:0] period_reg;
    logic [15:0] period_next;
    logic [15:0] remain_reg;
    logic [15:0] remain_next;
    token_t      tok_reg;
    token_t      tok_next;
    logic [15:0] remain_dec;
    logic        id_hit;

    assign remain_dec = remain_reg - 16'd1;
    assign id_hit     = ID_OK && (tok_in.timer_id == GRANT_ID);

    always_comb
    begin
        period_next = period_reg;
        remain_next = remain_reg;
        tok_next    = tok_in;
        if (tok_in.valid)
        begin
            case (tok_in.opcode)
                OP_TICK:
                begin
                    if (period_reg != 16'd0)
                    begin
                        if (remain_dec == 16'd0)
                        begin
                            // reload and flag expiry
                            remain_next           = period_reg;
                            tok_next.expired_mask = tok_in.expired_mask | EXP_BIT;
                        end
                        else
                        begin
                            remain_next = remain_dec;
                        end
                    end
                end
                OP_REQUEST:
                begin
                    if ((tok_in.period_ms != 16'd0) && !tok_in.claimed &&
                        (period_reg == 16'd0))
                    begin
                        period_next         = tok_in.period_ms;
                        remain_next         = tok_in.period_ms;
                        tok_next.claimed    = 1'b1;
                        tok_next.granted_id = GRANT_ID;
                    end
                end
                OP_SET_PERIOD:
                begin
                    if (id_hit)
                    begin
                        period_next = tok_in.period_ms;
                        remain_next = tok_in.period_ms;
                    end
                end
                OP_RESTART:
                begin
                    if (id_hit)
                        remain_next = period_reg;
                end
                OP_RELEASE:
                begin
                    if (id_hit)
                        period_next = 16'd0;
                end
                default:
                begin
                    period_next = period_reg;
                end
            endcase
            // count this slot after its update, saturating
            if ((period_next != 16'd0) && (tok_in.active_count != 4'd15))
                tok_next.active_count = tok_in.active_count + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= '0;
            remain_reg <= '0;
            tok_reg    <= '0;
        end
        else
        begin
            period_reg <= period_next;
            remain_reg <= remain_next;
            tok_reg    <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: rtl/periodic_timer_bank.sv
// Bank of NUM_TIMERS periodic down-counting timers with a 32-bit tick clock
// that counts accepted tick operations. Each input transfer is one operation
// (tick, request, set period, restart, release) and yields exactly one result
// transfer. The operation travels as a token along a chain of per-slot cells,
// one cell per cycle, and the chain's tail result is registered into the output
// buffer that drives m_tvalid. A new operation is accepted only once the previous
// token has left the chain and the skid entry is empty. A two-entry output buffer
// lets the next operation start while an earlier result waits on m_tready.
module periodic_timer_bank
    import ptb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // opcode[2:0], timer_id[5:3], period_ms[21:6], zero pad
    input  logic [IN_BYTES*8-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // status[1:0], granted_id[4:2], expired_mask[12:5], time_ms[44:13],
    // active_count[48:45], zero pad
    output logic [OUT_BYTES*8-1:0] m_tdata
);

    localparam int RES_W = $bits(result_t);

    token_t      tok [NUM_TIMERS+1];
    token_t      tail;
    logic        accept;
    logic        out_take;
    logic        busy_reg;
    logic        busy_next;
    logic [31:0] clock_reg;
    logic [31:0] clock_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        hold_valid_reg;
    logic        hold_valid_next;
    result_t     out_data_reg;
    result_t     out_data_next;
    result_t     hold_data_reg;
    result_t     hold_data_next;
    result_t     tail_res;

    assign s_tready = !busy_reg && !hold_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_take = out_valid_reg && m_tready;

    always_comb
    begin
        tok[0]              = '0;
        tok[0].valid        = accept;
        tok[0].opcode       = opcode_t'(s_tdata[2:0]);
        tok[0].timer_id     = s_tdata[5:3];
        tok[0].period_ms    = s_tdata[21:6];
    end

    for (genvar k = 0; k < NUM_TIMERS; k++)
    begin : g_cell
        ptb_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok[k]),
            .tok_out (tok[k+1])
        );
    end

    assign tail = tok[NUM_TIMERS];

    always_comb
    begin
        tail_res              = '0;
        tail_res.active_count = tail.active_count;
        tail_res.time_ms      = clock_reg;
        tail_res.expired_mask = tail.expired_mask;
        tail_res.granted_id   = tail.claimed ? tail.granted_id : 3'd0;
        tail_res.status       = ST_OK;
        if (tail.opcode == OP_REQUEST)
        begin
            if (tail.period_ms == 16'd0)
                tail_res.status = ST_ZERO;
            else if (!tail.claimed)
                tail_res.status = ST_FULL;
        end
    end

    always_comb
    begin
        clock_next = clock_reg;
        if (accept && (opcode_t'(s_tdata[2:0]) == OP_TICK))
            clock_next = clock_reg + 32'd1;

        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (tail.valid)
            busy_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        hold_valid_next = hold_valid_reg;
        hold_data_next  = hold_data_reg;
        if (out_take)
        begin
            if (hold_valid_reg)
            begin
                out_data_next   = hold_data_reg;
                hold_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (tail.valid)
        begin
            if (!out_valid_next)
            begin
                out_valid_next = 1'b1;
                out_data_next  = tail_res;
            end
            else
            begin
                // output still occupied: park in the skid entry
                hold_valid_next = 1'b1;
                hold_data_next  = tail_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            clock_reg      <= '0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            clock_reg      <= clock_next;
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        hold_data_reg <= hold_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_BYTES*8-RES_W){1'b0}}, out_data_reg};

`ifndef NO_ASSERTIONS
    a_tail_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> busy_reg)
        else $error("token left the chain with no operation in flight");

    a_tail_skid_free: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> !hold_valid_reg)
        else $error("result arrived while skid entry was full");

    a_hold_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result ahead of the output");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("accepted operation not marked in flight");

    a_zero_only_request: assert property (@(posedge clk) disable iff (!rst_n)
        (tail.valid && (tail_res.status != ST_OK)) |-> (tail.opcode == OP_REQUEST))
        else $error("error status on a non-request operation");
`endif

endmodule
